// File: hdl/awc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// awc_pkg
// Shared types and constants of the annular workspace clamp: register
// indexes, reset values, correction modes and the per-item control word.
// ============================================================================
package awc_pkg;

    // default coordinate width
    localparam int COORD_WIDTH_DEF = 19;

    // register widths
    localparam int RAD_W      = 18;
    localparam int HGT_W      = 19;
    localparam int CFG_DATA_W = 19;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RMIN   = 3'd0,
        CFG_RMAX   = 3'd1,
        CFG_HMIN   = 3'd2,
        CFG_HMAX   = 3'd3,
        CFG_OFFSET = 3'd4
    } cfg_idx_t;

    // reset values
    localparam logic [RAD_W-1:0] RMIN_RST   = 18'd6554;
    localparam logic [RAD_W-1:0] RMAX_RST   = 18'd26214;
    localparam logic [HGT_W-1:0] HMIN_RST   = 19'd0;
    localparam logic [HGT_W-1:0] HMAX_RST   = 19'd13107;
    localparam logic [HGT_W-1:0] OFFSET_RST = 19'd6554;

    // requested correction modes
    localparam logic [1:0] MODE_SOLVE_X = 2'd0;
    localparam logic [1:0] MODE_SOLVE_Y = 2'd1;

    // correction actually applied
    typedef enum logic [1:0] {
        FIX_NONE    = 2'd0,
        FIX_SOLVE_X = 2'd1,
        FIX_SOLVE_Y = 2'd2,
        FIX_SCALE   = 2'd3
    } fix_kind_t;

    // per-item control word carried down the pipeline
    typedef struct packed {
        fix_kind_t         kind;
        logic              zero;
        logic              dy_pos;
        logic              dy_neg;
        logic [RAD_W-1:0]  target;
    } item_ctl_t;

endpackage

// File: hdl/annular_workspace_clamp.sv
`timescale 1ns / 1ps
// ============================================================================
// annular_workspace_clamp
// Clamps a target point into a height band and moves it into the ring
// between the inner and outer radius about a shifted centre, by solving for
// x, solving for y or scaling radially.
//
//   channel   signals                              handshake
//   -------   ----------------------------------   ----------------------
//   request   start, in_x, in_y, in_z, fix_mode    start & !busy
//   result    done, out_x, out_y, out_z,           done, one cycle
//             was_moved, zero_radius
//   config    cfg_write, cfg_index, cfg_data       cfg_write, no wait
//
// One request per cycle. The square root has RW = max(COORD_WIDTH, 19) + 1
// root stages and the divider has QW = 19 quotient stages. busy stays low:
// the pipeline never stalls, and the receiver takes each result in its one
// done cycle.
// Reset clears the valid bits and loads the register reset values.
// ============================================================================
module annular_workspace_clamp #(
    parameter int COORD_WIDTH = awc_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_WIDTH-1:0]      in_x,
    input  logic signed [COORD_WIDTH-1:0]      in_y,
    input  logic signed [COORD_WIDTH-1:0]      in_z,
    input  logic [1:0]                         fix_mode,
    output logic                               done,
    output logic signed [COORD_WIDTH-1:0]      out_x,
    output logic signed [COORD_WIDTH-1:0]      out_y,
    output logic signed [COORD_WIDTH-1:0]      out_z,
    output logic                               was_moved,
    output logic                               zero_radius,
    input  logic                               cfg_write,
    input  logic [awc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [awc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int RADW = awc_pkg::RAD_W;
    localparam int HW   = awc_pkg::HGT_W;
    localparam int CWX  = (CW > HW) ? CW : HW;
    localparam int MW   = CWX + 1;
    localparam int D2W  = 2 * MW;
    localparam int RW   = MW;
    localparam int PW   = MW + RADW;
    localparam int NW   = PW + 1;
    localparam int QW   = RADW + 1;
    localparam int EW   = CWX + 2;
    localparam int L    = 7 + RW + QW;
    localparam int IE   = 4;
    localparam int IF   = 5 + RW;
    localparam int IG   = 6 + RW;
    localparam int IZ   = L - 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [RADW-1:0]        rmin_reg;
    logic [RADW-1:0]        rmax_reg;
    logic signed [HW-1:0]   hmin_reg;
    logic signed [HW-1:0]   hmax_reg;
    logic signed [HW-1:0]   off_reg;
    logic [2*RADW-1:0]      rmin2_reg;
    logic [2*RADW-1:0]      rmax2_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmin_reg <= awc_pkg::RMIN_RST;
            rmax_reg <= awc_pkg::RMAX_RST;
            hmin_reg <= awc_pkg::HMIN_RST;
            hmax_reg <= awc_pkg::HMAX_RST;
            off_reg  <= awc_pkg::OFFSET_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                awc_pkg::CFG_RMIN:   rmin_reg <= cfg_data[RADW-1:0];
                awc_pkg::CFG_RMAX:   rmax_reg <= cfg_data[RADW-1:0];
                awc_pkg::CFG_HMIN:   hmin_reg <= cfg_data[HW-1:0];
                awc_pkg::CFG_HMAX:   hmax_reg <= cfg_data[HW-1:0];
                awc_pkg::CFG_OFFSET: off_reg  <= cfg_data[HW-1:0];
                default:             ;
            endcase
        end
    end

    // squared radii, updated in the cycle after the radius registers
    always_ff @(posedge clk)
    begin
        rmin2_reg <= rmin_reg * rmin_reg;
        rmax2_reg <= rmax_reg * rmax_reg;
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // pipeline lines
    // ------------------------------------------------------------------
    logic                    vld_reg  [0:L-1];
    logic signed [CW-1:0]    x_reg    [0:L-1];
    logic signed [CW-1:0]    y_reg    [0:L-1];
    logic signed [CW-1:0]    z_reg    [0:L-1];
    logic [1:0]              mode_reg [0:IE-1];
    logic signed [MW-1:0]    dy_reg   [0:IE-1];
    logic [MW-1:0]           ax_reg   [1:IF-1];
    logic [MW-1:0]           ady_reg  [1:IF-1];
    awc_pkg::item_ctl_t      ctl_reg  [IE:L-1];
    logic [RW-1:0]           root_reg [IF:L-1];

    logic signed [MW-1:0]    dy_in;
    logic signed [MW-1:0]    x_ext;
    logic [MW-1:0]           ax_next;
    logic [MW-1:0]           ady_next;

    // offset from centre and magnitudes
    always_comb
    begin
        dy_in    = MW'(in_y) - MW'(off_reg);
        x_ext    = MW'(x_reg[0]);
        ax_next  = x_ext[MW-1] ? MW'(-x_ext) : MW'(x_ext);
        ady_next = dy_reg[0][MW-1] ? MW'(-dy_reg[0]) : MW'(dy_reg[0]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start & ~busy;
            for (int k = 1; k < L; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // coordinate, mode, offset and magnitude lines
    always_ff @(posedge clk)
    begin
        x_reg[0]    <= in_x;
        y_reg[0]    <= in_y;
        z_reg[0]    <= in_z;
        mode_reg[0] <= fix_mode;
        dy_reg[0]   <= dy_in;
        for (int k = 1; k < L; k++)
        begin
            x_reg[k] <= x_reg[k-1];
            y_reg[k] <= y_reg[k-1];
            z_reg[k] <= z_reg[k-1];
        end
        for (int k = 1; k < IE; k++)
        begin
            mode_reg[k] <= mode_reg[k-1];
            dy_reg[k]   <= dy_reg[k-1];
        end
        ax_reg[1]  <= ax_next;
        ady_reg[1] <= ady_next;
        for (int k = 2; k < IF; k++)
        begin
            ax_reg[k]  <= ax_reg[k-1];
            ady_reg[k] <= ady_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // squares and range flags, then squared radius and the two solve operands
    // ------------------------------------------------------------------
    logic [D2W-1:0] ax2_c_reg;
    logic [D2W-1:0] ady2_c_reg;
    logic           fx_c_reg;
    logic           fy_c_reg;
    logic [D2W-1:0] d2_d_reg;
    logic [D2W-1:0] rx_d_reg;
    logic [D2W-1:0] ry_d_reg;
    logic           fx_d_reg;
    logic           fy_d_reg;

    always_ff @(posedge clk)
    begin
        ax2_c_reg  <= ax_reg[1] * ax_reg[1];
        ady2_c_reg <= ady_reg[1] * ady_reg[1];
        fx_c_reg   <= ax_reg[1] > MW'(rmax_reg);
        fy_c_reg   <= ady_reg[1] > MW'(rmax_reg);
        d2_d_reg   <= ax2_c_reg + ady2_c_reg;
        rx_d_reg   <= D2W'(rmax2_reg) - ady2_c_reg;
        ry_d_reg   <= D2W'(rmax2_reg) - ax2_c_reg;
        fx_d_reg   <= fx_c_reg;
        fy_d_reg   <= fy_c_reg;
    end

    // ------------------------------------------------------------------
    // correction decision
    // ------------------------------------------------------------------
    awc_pkg::item_ctl_t ctl_next;
    logic [D2W-1:0]     sq_op_next;
    logic [D2W-1:0]     sq_op_reg;
    logic               gt;
    logic               lt;
    logic               radial;
    logic [1:0]         mode_d;

    always_comb
    begin
        mode_d          = mode_reg[IE-1];
        gt              = d2_d_reg > D2W'(rmax2_reg);
        lt              = d2_d_reg < D2W'(rmin2_reg);
        radial          = mode_d[1] | lt;
        ctl_next.kind   = awc_pkg::FIX_NONE;
        ctl_next.zero   = (d2_d_reg == '0);
        ctl_next.dy_neg = dy_reg[IE-1][MW-1];
        ctl_next.dy_pos = ~dy_reg[IE-1][MW-1] & (dy_reg[IE-1] != '0);
        ctl_next.target = gt ? rmax_reg : rmin_reg;
        sq_op_next      = '0;
        priority if (!radial && gt && mode_d == awc_pkg::MODE_SOLVE_X)
        begin
            if (fy_d_reg)
                radial = 1'b1;
            else
            begin
                ctl_next.kind = awc_pkg::FIX_SOLVE_X;
                sq_op_next    = rx_d_reg;
            end
        end
        else if (!radial && gt && mode_d == awc_pkg::MODE_SOLVE_Y)
        begin
            if (fx_d_reg)
                radial = 1'b1;
            else
            begin
                ctl_next.kind = awc_pkg::FIX_SOLVE_Y;
                sq_op_next    = ry_d_reg;
            end
        end
        else
        begin
        end
        if (radial && !ctl_next.zero && (gt || lt))
        begin
            ctl_next.kind = awc_pkg::FIX_SCALE;
            sq_op_next    = d2_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_op_reg   <= sq_op_next;
        ctl_reg[IE] <= ctl_next;
        for (int k = IE + 1; k < L; k++)
            ctl_reg[k] <= ctl_reg[k-1];
    end

    // ------------------------------------------------------------------
    // square root
    // ------------------------------------------------------------------
    logic          sq_valid;
    logic [RW-1:0] sq_root;

    awc_sqrt #(
        .OP_W (D2W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[IE]),
        .in_op     (sq_op_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root)
    );

    // ------------------------------------------------------------------
    // scale products, rounding offset, divider
    // ------------------------------------------------------------------
    logic [PW-1:0] px_reg;
    logic [PW-1:0] pdy_reg;
    logic [NW-1:0] nx_reg;
    logic [NW-1:0] ndy_reg;

    always_ff @(posedge clk)
    begin
        root_reg[IF] <= sq_root;
        for (int k = IF + 1; k < L; k++)
            root_reg[k] <= root_reg[k-1];
        px_reg  <= ax_reg[IF-1] * ctl_reg[IF-1].target;
        pdy_reg <= ady_reg[IF-1] * ctl_reg[IF-1].target;
        nx_reg  <= NW'(px_reg) + NW'(root_reg[IF] >> 1);
        ndy_reg <= NW'(pdy_reg) + NW'(root_reg[IF] >> 1);
    end

    logic          dv_valid;
    logic [QW-1:0] qx;
    logic [QW-1:0] qdy;

    awc_div #(
        .NUM_W (NW),
        .DEN_W (RW),
        .QUO_W (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[IG] & sq_valid | vld_reg[IG]),
        .in_num_a  (nx_reg),
        .in_num_b  (ndy_reg),
        .in_den    (root_reg[IG]),
        .out_valid (dv_valid),
        .out_quo_a (qx),
        .out_quo_b (qdy)
    );

    // ------------------------------------------------------------------
    // result assembly, saturation and flags
    // ------------------------------------------------------------------
    awc_pkg::item_ctl_t      ctl_z;
    logic signed [EW-1:0]    xe;
    logic signed [EW-1:0]    ye;
    logic signed [EW-1:0]    root_e;
    logic signed [EW-1:0]    qx_e;
    logic signed [EW-1:0]    qdy_e;
    logic signed [EW-1:0]    off_e;
    logic signed [EW-1:0]    sat_hi;
    logic signed [EW-1:0]    sat_lo;
    logic signed [CW-1:0]    xs;
    logic signed [CW-1:0]    ys;
    logic signed [CWX-1:0]   zw;
    logic signed [CWX-1:0]   zo;
    logic                    moved;

    always_comb
    begin
        ctl_z  = ctl_reg[IZ];
        root_e = EW'(root_reg[IZ]);
        qx_e   = EW'(qx);
        qdy_e  = EW'(qdy);
        off_e  = EW'(off_reg);
        sat_hi = EW'({1'b0, {(CW-1){1'b1}}});
        sat_lo = -sat_hi - EW'(1);
        xe     = EW'(x_reg[IZ]);
        ye     = EW'(y_reg[IZ]);
        unique case (ctl_z.kind)
            awc_pkg::FIX_SOLVE_X:
                xe = (x_reg[IZ] > 0) ? root_e : -root_e;
            awc_pkg::FIX_SOLVE_Y:
                ye = ctl_z.dy_pos ? off_e + root_e : off_e - root_e;
            awc_pkg::FIX_SCALE:
            begin
                xe = x_reg[IZ][CW-1] ? -qx_e : qx_e;
                ye = (ctl_z.dy_neg ? -qdy_e : qdy_e) + off_e;
            end
            default:
            begin
            end
        endcase

        // saturate to the coordinate range
        if (xe > sat_hi)
            xs = CW'(sat_hi);
        else if (xe < sat_lo)
            xs = CW'(sat_lo);
        else
            xs = CW'(xe);
        if (ye > sat_hi)
            ys = CW'(sat_hi);
        else if (ye < sat_lo)
            ys = CW'(sat_lo);
        else
            ys = CW'(ye);

        // height clamp, upper bound first
        zw = CWX'(z_reg[IZ]);
        if (zw > CWX'(hmax_reg))
            zo = CWX'(hmax_reg);
        else if (zw < CWX'(hmin_reg))
            zo = CWX'(hmin_reg);
        else
            zo = zw;

        moved = (xs != x_reg[IZ]) || (ys != y_reg[IZ]) || (zo != zw);
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= vld_reg[IZ] & dv_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_x       <= xs;
        out_y       <= ys;
        out_z       <= CW'(zo);
        was_moved   <= moved;
        zero_radius <= ctl_z.zero;
    end

endmodule

// File: hdl/awc_sqrt.sv
`timescale 1ns / 1ps
// ============================================================================
// awc_sqrt
// Pipelined integer floor square root, one result bit per stage.
// ============================================================================
module awc_sqrt #(
    parameter int OP_W = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [OP_W-1:0]     in_op,
    output logic                out_valid,
    output logic [OP_W/2-1:0]   out_root
);

    localparam int RW = OP_W / 2;

    logic [RW+1:0]   rem_reg  [0:RW-1];
    logic [RW-1:0]   root_reg [0:RW-1];
    logic [OP_W-1:0] op_reg   [0:RW-1];
    logic            vld_reg  [0:RW-1];

    genvar i;
    generate
        for (i = 0; i < RW; i++)
        begin : g_stage
            logic [RW+1:0]   rem_prev;
            logic [RW-1:0]   root_prev;
            logic [OP_W-1:0] op_prev;
            logic            vld_prev;
            logic [RW+1:0]   rem_sh;
            logic [RW+1:0]   trial;
            logic [RW+1:0]   rem_next;
            logic [RW-1:0]   root_next;

            // stage input select
            if (i == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign op_prev   = in_op;
                assign vld_prev  = in_valid;
            end
            else
            begin : g_rest
                assign rem_prev  = rem_reg[i-1];
                assign root_prev = root_reg[i-1];
                assign op_prev   = op_reg[i-1];
                assign vld_prev  = vld_reg[i-1];
            end

            // one root bit
            always_comb
            begin
                rem_sh = {rem_prev[RW-1:0], op_prev[OP_W-1:OP_W-2]};
                trial  = {root_prev, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_prev[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_prev[RW-2:0], 1'b0};
                end
            end

            // valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else
                    vld_reg[i] <= vld_prev;
            end

            // data
            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                op_reg[i]   <= op_prev << 2;
            end
        end
    endgenerate

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];

endmodule

// File: hdl/awc_div.sv
`timescale 1ns / 1ps
// ============================================================================
// awc_div
// Pipelined restoring divider, two numerator lanes over one shared divisor,
// one quotient bit per stage.
// ============================================================================
module awc_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 20,
    parameter int QUO_W = 19
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num_a,
    input  logic [NUM_W-1:0]  in_num_b,
    input  logic [DEN_W-1:0]  in_den,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo_a,
    output logic [QUO_W-1:0]  out_quo_b
);

    localparam int CMP_W = NUM_W + DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_a_reg [0:QUO_W-1];
    logic [NUM_W-1:0] rem_b_reg [0:QUO_W-1];
    logic [QUO_W-1:0] quo_a_reg [0:QUO_W-1];
    logic [QUO_W-1:0] quo_b_reg [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg   [0:QUO_W-1];
    logic             vld_reg   [0:QUO_W-1];

    genvar i;
    generate
        for (i = 0; i < QUO_W; i++)
        begin : g_stage
            logic [NUM_W-1:0] ra_prev;
            logic [NUM_W-1:0] rb_prev;
            logic [QUO_W-1:0] qa_prev;
            logic [QUO_W-1:0] qb_prev;
            logic [DEN_W-1:0] d_prev;
            logic             v_prev;
            logic [CMP_W-1:0] dsh;
            logic             take_a;
            logic             take_b;

            // stage input select
            if (i == 0)
            begin : g_first
                assign ra_prev = in_num_a;
                assign rb_prev = in_num_b;
                assign qa_prev = '0;
                assign qb_prev = '0;
                assign d_prev  = in_den;
                assign v_prev  = in_valid;
            end
            else
            begin : g_rest
                assign ra_prev = rem_a_reg[i-1];
                assign rb_prev = rem_b_reg[i-1];
                assign qa_prev = quo_a_reg[i-1];
                assign qb_prev = quo_b_reg[i-1];
                assign d_prev  = den_reg[i-1];
                assign v_prev  = vld_reg[i-1];
            end

            // trial subtract of the shifted divisor
            always_comb
            begin
                dsh    = CMP_W'(d_prev) << (QUO_W - 1 - i);
                take_a = (CMP_W'(ra_prev) >= dsh);
                take_b = (CMP_W'(rb_prev) >= dsh);
            end

            // valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[i] <= 1'b0;
                else
                    vld_reg[i] <= v_prev;
            end

            // data
            always_ff @(posedge clk)
            begin
                rem_a_reg[i] <= take_a ? ra_prev - dsh[NUM_W-1:0] : ra_prev;
                rem_b_reg[i] <= take_b ? rb_prev - dsh[NUM_W-1:0] : rb_prev;
                quo_a_reg[i] <= {qa_prev[QUO_W-2:0], take_a};
                quo_b_reg[i] <= {qb_prev[QUO_W-2:0], take_b};
                den_reg[i]   <= d_prev;
            end
        end
    endgenerate

    assign out_valid = vld_reg[QUO_W-1];
    assign out_quo_a = quo_a_reg[QUO_W-1];
    assign out_quo_b = quo_b_reg[QUO_W-1];

endmodule
